>>> hw/rtl/indexed_list_insert_remove_unit_assert.svh
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ILR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list unit check failed");

// Next-cycle implication, checked out of reset.
`define ILR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list unit check failed");

`endif

>>> hw/rtl/ilr_pkg.sv
package ilr_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Per-cell command for one cycle.
  typedef struct packed {
    logic shift_up;    // take the entry of the lower neighbor
    logic shift_down;  // take the entry of the upper neighbor
    logic load;        // take the new value
  } cell_ctrl_t;

endpackage

>>> hw/rtl/indexed_list_insert_remove_unit.sv
// Channel | Handshake                  | Payload
// --------+----------------------------+---------------------------------------------
// in      | in_valid / in_stall        | operation, position, item_value
// out     | out_valid / out_stall      | read_value, item_count, is_empty, status
//
// Cycles: one item per cycle while in_stall is low; the result sits in the output register in the next cycle.
// Every later entry shifts in the same cycle as the insert or remove.
// Reset: synchronous rst clears the count and the output valid; entry cells
// hold no reset value and are only read after an insert or set wrote them.
// Stalls: in_stall rises only while a result waits in the output register
// under out_stall; an item is taken in the same cycle that result leaves.
`include "indexed_list_insert_remove_unit_assert.svh"

module indexed_list_insert_remove_unit
  import ilr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] read_value,
  output logic [4:0]               item_count,
  output logic                     is_empty,
  output logic [1:0]               status
);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     in_accept;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic [1:0]               st;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     set_ok;
  logic                     get_ok;
  logic signed [DATA_W-1:0] rd;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  cell_ctrl_t               cell_ctrl  [CAPACITY];

  // Stall input only while a result is held back on the output side.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);

  // Decode the operation and its bound checks.
  always_comb begin
    st     = ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    set_ok = 1'b0;
    get_ok = 1'b0;
    case (op_t'(operation))
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st = ST_POS;
        end else if (cnt_c >= CMP_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          ins_ok = in_accept;
        end
      end
      OP_REMOVE: begin
        if (pos_c >= cnt_c) st = ST_POS;
        else rem_ok = in_accept;
      end
      OP_SET: begin
        if (pos_c >= cnt_c) st = ST_POS;
        else set_ok = in_accept;
      end
      OP_GET: begin
        if (pos_c >= cnt_c) st = ST_POS;
        else get_ok = 1'b1;
      end
      default: st = ST_POS;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (rem_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Get reads one cell; the index is in range whenever get_ok is set.
  assign rd = get_ok ? cell_value[position[IDX_W-1:0]] : '0;

  // Row of entry cells: each cell looks at its own index against the
  // position and the count, and moves data one place along the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CMP_W-1:0]         idx;
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;

    assign idx = CMP_W'(i);

    assign cell_ctrl[i].shift_up   = ins_ok && (idx > pos_c) && (idx <= cnt_c);
    assign cell_ctrl[i].shift_down = rem_ok && (idx >= pos_c) &&
                                     ((idx + CMP_W'(1)) < cnt_c);
    assign cell_ctrl[i].load       = (ins_ok || set_ok) && (idx == pos_c);

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_value[i+1];
    end

    ilr_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .lower_value (lower),
      .upper_value (upper),
      .load_value  (item_value),
      .value       (cell_value[i])
    );
  end

  // Advance the count; capture the result; drop valid once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_value <= rd;
      item_count <= 5'(count_next);
      is_empty   <= (count_next == '0);
      status     <= st;
    end
  end

  `ILR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `ILR_ASSERT_NEXT(a_insert_grows, ins_ok, count == $past(count) + CNT_W'(1))
  `ILR_ASSERT_NOW(a_full_only_at_cap, out_valid && status == ST_FULL, count == CNT_W'(CAPACITY))

endmodule

>>> hw/rtl/ilr_cell.sv
module ilr_cell
  import ilr_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] lower_value,
  input  logic signed [DATA_W-1:0] upper_value,
  input  logic signed [DATA_W-1:0] load_value,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] entry;

  // Load wins; a shift moves one place; otherwise hold.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_value;
    end else if (ctrl.shift_up) begin
      entry <= lower_value;
    end else if (ctrl.shift_down) begin
      entry <= upper_value;
    end
  end

  assign value = entry;

endmodule
